/* src/ware_pkg.sv */
// ----------------------------------------------------------------------------
// Windowed angle rate estimator: shared definitions
// Window geometry, field widths, operation codes, controller states and the
// command and status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package ware_pkg;

    // Window of stored samples.
    localparam int WINDOW_DEPTH = 16;
    localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
    localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);

    // Field widths.
    localparam int ANGLE_W = 17;
    localparam int TIME_W  = 32;
    localparam int LIMIT_W = 16;
    localparam int AXES    = 3;

    localparam logic [LIMIT_W-1:0] RATE_LIMIT_RESET = LIMIT_W'(18000);

    // Angles are hundredths of a degree and times are milliseconds, so the
    // angle difference is scaled by 1000 to give hundredths per second.
    localparam int RATE_SCALE = 1000;
    localparam int SCALE_W    = 10;
    // Largest angle difference magnitude times the scale fits in NUM_W bits.
    localparam int NUM_W      = 27;
    localparam int CNT_W      = $clog2(NUM_W);
    // A positive time span is below 2^31, and so is every partial remainder.
    localparam int REM_W      = TIME_W - 1;

    typedef enum logic [0:0] {
        OP_SAMPLE = 1'b0,
        OP_CLEAR  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STORE,
        ST_FETCH,
        ST_SCALE,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0]         stamp;
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] yaw;
    } row_t;

    typedef struct packed {
        logic capture;
        logic clear;
        logic store;
        logic prepare;
        logic scale;
        logic div_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic out_busy;
    } status_t;

endpackage

/* src/ware_ctrl.sv */
// ----------------------------------------------------------------------------
// Windowed angle rate estimator: controller
// Sequences one sample through store, fetch of the oldest entry, scaling,
// the bit-serial division and the hand-over to the output register.
// ----------------------------------------------------------------------------
module ware_ctrl
    import ware_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    op,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (op == OP_CLEAR)
                    begin
                        cmd.clear = 1'b1;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_STORE;
                    end
                end
            end
            ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                cmd.prepare = 1'b1;
                state_next  = ST_SCALE;
            end
            ST_SCALE:
            begin
                // A window with fewer than two entries or without a positive span needs no quotient.
                if (status.skip)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.scale  = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* src/ware_datapath.sv */
// ----------------------------------------------------------------------------
// Windowed angle rate estimator: datapath
// Sample window memory, slot and fill tracking, three divider lanes that
// share one time span, clamping and the output register.
// ----------------------------------------------------------------------------
module ware_datapath
    import ware_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output status_t                   status,
    input  logic                      cfg_valid,
    input  logic [LIMIT_W-1:0]        cfg_data,
    input  logic signed [ANGLE_W-1:0] pitch_angle,
    input  logic signed [ANGLE_W-1:0] roll_angle,
    input  logic signed [ANGLE_W-1:0] yaw_angle,
    input  logic [TIME_W-1:0]         sample_time_ms,
    input  logic                      dizzy_in,
    input  logic                      out_stall,
    output logic                      out_valid,
    output logic signed [ANGLE_W-1:0] pitch_rate,
    output logic signed [ANGLE_W-1:0] roll_rate,
    output logic signed [ANGLE_W-1:0] yaw_rate,
    output logic                      dizzy_out,
    output logic                      rate_valid
);

    row_t window_mem [WINDOW_DEPTH];

    // Control state.
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [LIMIT_W-1:0] rate_limit_reg;
    logic               out_valid_reg;

    // Payload.
    row_t                      new_row_reg;
    row_t                      old_row_reg;
    logic                      dizzy_reg;
    logic                      few_reg;
    logic                      skip_reg;
    logic [TIME_W-1:0]         dt_reg;
    logic [ANGLE_W-1:0]        mag_reg [AXES];
    logic                      neg_reg [AXES];
    logic [NUM_W-1:0]          num_reg [AXES];
    logic [REM_W-1:0]          rem_reg [AXES];
    logic signed [ANGLE_W-1:0] rate_reg [AXES];
    logic                      dizzy_out_reg;
    logic                      rate_valid_reg;

    logic [SLOT_W-1:0]         oldest;
    logic [FILL_W:0]           slot_ext;
    logic [TIME_W-1:0]         dt;
    logic signed [ANGLE_W-1:0] new_angle [AXES];
    logic signed [ANGLE_W-1:0] old_angle [AXES];
    logic signed [ANGLE_W:0]   diff [AXES];
    logic [ANGLE_W:0]          diff_abs [AXES];
    logic [REM_W:0]            trial [AXES];
    logic                      fits [AXES];
    logic [LIMIT_W-1:0]        clamped [AXES];
    logic [ANGLE_W-1:0]        clamped_ext [AXES];
    logic signed [ANGLE_W-1:0] rate [AXES];

    // Slot and fill after the current sample is stored.
    always_comb
    begin
        if (slot_reg == SLOT_W'(WINDOW_DEPTH - 1))
        begin
            slot_next = '0;
        end
        else
        begin
            slot_next = slot_reg + 1'b1;
        end
        if (fill_reg < FILL_W'(WINDOW_DEPTH))
        begin
            fill_next = fill_reg + 1'b1;
        end
        else
        begin
            fill_next = fill_reg;
        end
        // The oldest entry sits fill slots behind the next write slot.
        slot_ext = (FILL_W + 1)'(slot_next);
        if (slot_ext >= {1'b0, fill_next})
        begin
            oldest = SLOT_W'(slot_ext - {1'b0, fill_next});
        end
        else
        begin
            oldest = SLOT_W'(slot_ext + (FILL_W + 1)'(WINDOW_DEPTH) - {1'b0, fill_next});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg       <= '0;
            fill_reg       <= '0;
            rate_limit_reg <= RATE_LIMIT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                slot_reg <= '0;
                fill_reg <= '0;
            end
            else if (cmd.store)
            begin
                slot_reg <= slot_next;
                fill_reg <= fill_next;
            end
            if (cfg_valid)
            begin
                rate_limit_reg <= cfg_data;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Window memory: one write and one registered read per cycle, both on a store. The read
    // address never equals the write address, as the window holds two or
    // more entries whenever the oldest one matters.
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            window_mem[slot_reg] <= new_row_reg;
            old_row_reg          <= window_mem[oldest];
        end
    end

    assign dt = new_row_reg.stamp - old_row_reg.stamp;

    assign new_angle[0] = new_row_reg.pitch;
    assign new_angle[1] = new_row_reg.roll;
    assign new_angle[2] = new_row_reg.yaw;
    assign old_angle[0] = old_row_reg.pitch;
    assign old_angle[1] = old_row_reg.roll;
    assign old_angle[2] = old_row_reg.yaw;

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            diff[i] = (ANGLE_W + 1)'(new_angle[i]) - (ANGLE_W + 1)'(old_angle[i]);
            if (diff[i][ANGLE_W])
            begin
                diff_abs[i] = -diff[i];
            end
            else
            begin
                diff_abs[i] = diff[i];
            end
            trial[i] = {rem_reg[i], num_reg[i][NUM_W-1]};
            fits[i]  = trial[i] >= dt_reg;
            if (num_reg[i] > NUM_W'(rate_limit_reg))
            begin
                clamped[i] = rate_limit_reg;
            end
            else
            begin
                clamped[i] = num_reg[i][LIMIT_W-1:0];
            end
            clamped_ext[i] = ANGLE_W'(clamped[i]);
            if (skip_reg)
            begin
                rate[i] = '0;
            end
            else if (neg_reg[i])
            begin
                rate[i] = -clamped_ext[i];
            end
            else
            begin
                rate[i] = clamped_ext[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            new_row_reg.stamp <= sample_time_ms;
            new_row_reg.pitch <= pitch_angle;
            new_row_reg.roll  <= roll_angle;
            new_row_reg.yaw   <= yaw_angle;
            dizzy_reg         <= dizzy_in;
        end
        if (cmd.store)
        begin
            few_reg <= fill_next < FILL_W'(2);
        end
        if (cmd.prepare)
        begin
            dt_reg   <= dt;
            // A span of zero or with the sign bit set counts as non-positive.
            skip_reg <= few_reg || (dt == '0) || dt[TIME_W-1];
            for (int i = 0; i < AXES; i++)
            begin
                mag_reg[i] <= diff_abs[i][ANGLE_W-1:0];
                neg_reg[i] <= diff[i][ANGLE_W];
            end
        end
        for (int i = 0; i < AXES; i++)
        begin
            if (cmd.scale)
            begin
                num_reg[i] <= NUM_W'(mag_reg[i]) * NUM_W'(RATE_SCALE);
                rem_reg[i] <= '0;
            end
            else if (cmd.div_step)
            begin
                // Restoring division: one quotient bit per cycle, shifted in
                // behind the dividend bits still to be consumed.
                num_reg[i] <= {num_reg[i][NUM_W-2:0], fits[i]};
                if (fits[i])
                begin
                    rem_reg[i] <= REM_W'(trial[i] - dt_reg);
                end
                else
                begin
                    rem_reg[i] <= trial[i][REM_W-1:0];
                end
            end
        end
        if (cmd.finish)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                rate_reg[i] <= rate[i];
            end
            dizzy_out_reg  <= dizzy_reg;
            rate_valid_reg <= !skip_reg;
        end
    end

    assign status.skip     = skip_reg;
    assign status.out_busy = out_valid_reg && out_stall;

    assign out_valid  = out_valid_reg;
    assign pitch_rate = rate_reg[0];
    assign roll_rate  = rate_reg[1];
    assign yaw_rate   = rate_reg[2];
    assign dizzy_out  = dizzy_out_reg;
    assign rate_valid = rate_valid_reg;

endmodule

/* src/windowed_angle_rate_estimator_core.sv */
// ----------------------------------------------------------------------------
// Windowed angle rate estimator
// Angular rates of pitch, roll and yaw over a window of the last sixteen
// timestamped samples, clamped to a programmable limit.
//
//   Channel  Signals                                      Direction
//   -------  -------------------------------------------  ---------
//   in       in_valid, in_stall, op, pitch_angle,         into block
//            roll_angle, yaw_angle, sample_time_ms,
//            dizzy_in
//   out      out_valid, out_stall, pitch_rate, roll_rate,  out of block
//            yaw_rate, dizzy_out, rate_valid
//   cfg      cfg_valid, cfg_ready, cfg_data (rate_limit)  into block
//
// A sample word's result is offered after store, fetch of the oldest entry,
// scaling, the three-lane bit-serial divider and the output load. The next
// word is taken once the controller is back in idle; the output load waits
// while an earlier result is still stalled. A window with fewer than two
// entries or without a positive span skips the divider. A clear word is
// taken without a stall and gives no word.
// The output register lets the next input word be taken while a result is
// still stalled. Reset empties the window and sets rate_limit to 18000.
// ----------------------------------------------------------------------------
module windowed_angle_rate_estimator_core
    import ware_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      op,
    input  logic signed [ANGLE_W-1:0] pitch_angle,
    input  logic signed [ANGLE_W-1:0] roll_angle,
    input  logic signed [ANGLE_W-1:0] yaw_angle,
    input  logic [TIME_W-1:0]         sample_time_ms,
    input  logic                      dizzy_in,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [ANGLE_W-1:0] pitch_rate,
    output logic signed [ANGLE_W-1:0] roll_rate,
    output logic signed [ANGLE_W-1:0] yaw_rate,
    output logic                      dizzy_out,
    output logic                      rate_valid,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [LIMIT_W-1:0]        cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    ware_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ware_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .pitch_angle    (pitch_angle),
        .roll_angle     (roll_angle),
        .yaw_angle      (yaw_angle),
        .sample_time_ms (sample_time_ms),
        .dizzy_in       (dizzy_in),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .pitch_rate     (pitch_rate),
        .roll_rate      (roll_rate),
        .yaw_rate       (yaw_rate),
        .dizzy_out      (dizzy_out),
        .rate_valid     (rate_valid)
    );

endmodule

/* src/ware_checker.sv */
// ----------------------------------------------------------------------------
// Windowed angle rate estimator: port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module ware_checker
    import ware_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      op,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic signed [ANGLE_W-1:0] pitch_rate,
    input logic signed [ANGLE_W-1:0] roll_rate,
    input logic signed [ANGLE_W-1:0] yaw_rate,
    input logic                      rate_valid
);

    // A stalled result word stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // A result without a valid rate carries zero rates.
    a_zero_rates: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !rate_valid |-> pitch_rate == '0 && roll_rate == '0 && yaw_rate == '0)
        else $error("non-zero rate on an invalid result");

    // A sample word keeps the block busy for at least the next cycle.
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op == OP_SAMPLE |=> in_stall)
        else $error("input taken again straight after a sample");

    // A clear word is absorbed at once.
    a_clear_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op == OP_CLEAR |=> !in_stall)
        else $error("input stalled after a clear");

endmodule

bind windowed_angle_rate_estimator_core ware_checker u_ware_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pitch_rate (pitch_rate),
    .roll_rate  (roll_rate),
    .yaw_rate   (yaw_rate),
    .rate_valid (rate_valid)
);
